// ===== hdl/rs_pkg.sv =====
// Shared types and constants for the reservoir sampler.
package rs_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the ports
	localparam int WORD_W  = 32;
	localparam int SIZE_W  = 7;
	localparam int INDEX_W = 6;

	// Galois LFSR, x^32+x^22+x^2+x+1, right shifting
	localparam logic [WORD_W-1:0] LFSR_SEED = 32'hACE1_135F;
	localparam logic [WORD_W-1:0] LFSR_TAPS = 32'h8020_0003;

	typedef enum logic {
		CMD_OFFER = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	// draw pair handed from the random source to the pipeline
	typedef struct packed {
		logic [WORD_W-1:0] r1;
		logic [WORD_W-1:0] r2;
	} draw_t;

endpackage

// ===== hdl/rs_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module rs_ram import rs_pkg::*; #(
	parameter int WIDTH = DATA_WIDTH_DEF,
	parameter int DEPTH = SLOT_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/rs_rng.sv =====
// LFSR random source: two advances per offered word.
module rs_rng import rs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	output draw_t draw
);

	logic [WORD_W-1:0] lfsr_q;

	function automatic logic [WORD_W-1:0] advance(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	always_comb begin
		draw.r1 = advance(lfsr_q);
		draw.r2 = advance(draw.r1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (step) begin
			lfsr_q <= draw.r2;
		end
	end

endmodule

// ===== hdl/reservoir_sampler_unit.sv =====
// Reservoir sampler top level: Algorithm R over a slot RAM.
// Three register stages (multiply, RAM access, output) lie between input accept
// and result valid.
// Throughput: one word per cycle while out_ready holds; the slot RAM takes at most one write or one read per word.
// Counters and LFSR update at accept; replacement decision and slot write as the word leaves stage 2.
// Reset (arst_n low, async): counts cleared, LFSR seeded, size = min(64, SLOT_COUNT).
// Slot RAM contents are not reset; no clearing pass.
module reservoir_sampler_unit import rs_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// config write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SIZE_W-1:0]  reservoir_size,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [WORD_W-1:0]  datum,
	input  logic [INDEX_W-1:0] read_index,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               stored,
	output logic [INDEX_W-1:0] slot,
	output logic [WORD_W-1:0]  read_data,
	output logic [SIZE_W-1:0]  fill_level,
	output logic [WORD_W-1:0]  items_seen
);

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int DW = DATA_WIDTH;
	localparam int SIZE_LIM  = (1 << SIZE_W) - 1;
	localparam int SIZE_MAXI = (SLOT_COUNT > SIZE_LIM) ? SIZE_LIM : SLOT_COUNT;
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(SIZE_MAXI);
	localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'((SIZE_MAXI < 64) ? SIZE_MAXI : 64);
	localparam logic [WORD_W-1:0] SLOTS_W  = WORD_W'(SLOT_COUNT);

	// ---------------- config: size is stored already clamped ----------------
	logic [SIZE_W-1:0] size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
		end else if (cfg_valid) begin
			if (reservoir_size == '0) begin
				size_q <= SIZE_W'(1);
			end else if (reservoir_size > SIZE_MAX) begin
				size_q <= SIZE_MAX;
			end else begin
				size_q <= reservoir_size;
			end
		end
	end

	// ---------------- stage flow: each stage moves when the next frees ----------------
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic accept, offer0;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;
	assign offer0   = accept && (command == CMD_OFFER);

	// ---------------- stage 0: counters and random draws ----------------
	// Fill and seen counts live in flops and update at accept, so a word
	// behind never waits on one ahead of it.
	logic [SIZE_W-1:0] fill_q;
	logic [WORD_W-1:0] seen_q;
	logic [WORD_W-1:0] seen_nxt;
	logic              append0;
	draw_t             draw;

	rs_rng u_rng (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (offer0),
		.draw  (draw)
	);

	assign seen_nxt = (seen_q == '1) ? seen_q : seen_q + WORD_W'(1);
	assign append0  = fill_q < size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			seen_q <= '0;
		end else if (offer0) begin
			seen_q <= seen_nxt;
			if (append0) begin
				fill_q <= fill_q + SIZE_W'(1);
			end
		end
	end

	// ---------------- stage 1: probability and slot products ----------------
	logic               rd_s1, app_s1;
	logic [WORD_W-1:0]  datum_s1, seen_s1, r1_s1, r2_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [SIZE_W-1:0]  aslot_s1, size_s1, fill_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1    <= (command == CMD_READ);
			app_s1   <= append0;
			datum_s1 <= datum;
			idx_s1   <= read_index;
			aslot_s1 <= fill_q;
			size_s1  <= size_q;
			r1_s1    <= draw.r1;
			r2_s1    <= draw.r2;
			// counts as seen after this word
			seen_s1  <= (command == CMD_OFFER) ? seen_nxt : seen_q;
			fill_s1  <= (command == CMD_OFFER && append0) ? fill_q + SIZE_W'(1) : fill_q;
		end
	end

	logic [2*WORD_W-1:0]      prod_keep;
	logic [WORD_W+SIZE_W-1:0] prod_slot;

	// r1*count < size*2^32 reduces to a compare of the upper half against size
	assign prod_keep = 64'(r1_s1) * 64'(seen_s1);
	assign prod_slot = (WORD_W+SIZE_W)'(r2_s1) * (WORD_W+SIZE_W)'(size_s1);

	// ---------------- stage 2: decision, slot write or read issue ----------------
	logic               rd_s2, app_s2;
	logic [WORD_W-1:0]  datum_s2, seen_s2, hi_s2;
	logic [INDEX_W-1:0] idx_s2;
	logic [SIZE_W-1:0]  aslot_s2, dslot_s2, size_s2, fill_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			rd_s2    <= rd_s1;
			app_s2   <= app_s1;
			datum_s2 <= datum_s1;
			idx_s2   <= idx_s1;
			aslot_s2 <= aslot_s1;
			dslot_s2 <= prod_slot[WORD_W+SIZE_W-1:WORD_W];
			size_s2  <= size_s1;
			fill_s2  <= fill_s1;
			seen_s2  <= seen_s1;
			hi_s2    <= prod_keep[2*WORD_W-1:WORD_W];
		end
	end

	logic              keep_s2, store_s2, go_s2;
	logic [SIZE_W-1:0] wslot_s2;
	logic              inrange_s2;

	assign keep_s2    = hi_s2 < WORD_W'(size_s2);
	assign store_s2   = !rd_s2 && (app_s2 || keep_s2);
	assign wslot_s2   = app_s2 ? aslot_s2 : dslot_s2;
	assign go_s2      = v_s2 && en3;
	assign inrange_s2 = WORD_W'(idx_s2) < SLOTS_W;

	// Writes and reads both happen as a word leaves stage 2, in order, so a read
	// always sees every write from words ahead of it: no forwarding needed.
	logic [AW+SIZE_W-1:0]  waddr_ext;
	logic [AW+INDEX_W-1:0] raddr_ext;
	logic [DW+WORD_W-1:0]  wdata_ext;
	logic [DW-1:0]         ram_rdata;

	assign waddr_ext = {{AW{1'b0}}, wslot_s2};
	assign raddr_ext = {{AW{1'b0}}, idx_s2};
	assign wdata_ext = {{DW{1'b0}}, datum_s2};

	rs_ram #(
		.WIDTH(DW),
		.DEPTH(SLOT_COUNT)
	) u_store (
		.clk  (clk),
		.we   (go_s2 && store_s2),
		.waddr(waddr_ext[AW-1:0]),
		.wdata(wdata_ext[DW-1:0]),
		.re   (go_s2 && rd_s2 && inrange_s2),
		.raddr(raddr_ext[AW-1:0]),
		.rdata(ram_rdata)
	);

	// ---------------- stage 3: result register ----------------
	// RAM read data holds while the result stalls, since reads fire only on advance.
	logic               rdok_s3, stored_s3;
	logic [INDEX_W-1:0] slot_s3;
	logic [SIZE_W-1:0]  fill_s3;
	logic [WORD_W-1:0]  seen_s3;
	logic [DW+WORD_W-1:0] rdata_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			rdok_s3   <= rd_s2 && inrange_s2;
			stored_s3 <= store_s2;
			slot_s3   <= store_s2 ? wslot_s2[INDEX_W-1:0] : '0;
			fill_s3   <= fill_s2;
			seen_s3   <= seen_s2;
		end
	end

	assign rdata_ext  = {{WORD_W{1'b0}}, ram_rdata};

	assign out_valid  = v_s3;
	assign stored     = stored_s3;
	assign slot       = slot_s3;
	assign read_data  = rdok_s3 ? rdata_ext[WORD_W-1:0] : '0;
	assign fill_level = fill_s3;
	assign items_seen = seen_s3;

endmodule
